/* sv/mpq_pkg.sv */
package mpq_pkg;

  localparam int unsigned KeyW        = 64;
  localparam int unsigned CountW      = 7;
  localparam int unsigned DefCapacity = 64;

  localparam logic [KeyW-1:0] KeyAllOnes = {KeyW{1'b1}};

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } mpq_status_e;

  // operation broadcast to every cell
  typedef struct packed {
    logic            ins;
    logic            ext;
    logic [KeyW-1:0] key;
  } mpq_op_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic            valid;
    logic            ahead;   // broadcast key sorts ahead of this cell
    logic [KeyW-1:0] key;
  } mpq_link_t;

endpackage

/* sv/mpq_if.sv */
interface mpq_in_if
  import mpq_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [KeyW-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface mpq_out_if
  import mpq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KeyW-1:0]   extracted;
  logic [1:0]        status;
  logic [CountW-1:0] count;
  logic [KeyW-1:0]   current_min;

  modport source (output valid, output extracted, output status, output count,
                  output current_min, input ready);
  modport sink   (input valid, input extracted, input status, input count,
                  input current_min, output ready);
endinterface

/* sv/mpq_cell.sv */
module mpq_cell
  import mpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mpq_op_t   op_i,
  input  mpq_link_t left_i,
  input  mpq_link_t right_i,
  output mpq_link_t link_o
);

  logic            valid_q, valid_d;
  logic [KeyW-1:0] key_q, key_d;
  logic            ahead;

  assign ahead = !valid_q || (op_i.key < key_q);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (op_i.ins) begin
      if (left_i.ahead) begin
        // shift right to open the slot further left
        valid_d = left_i.valid;
        key_d   = left_i.key;
      end else if (ahead) begin
        valid_d = 1'b1;
        key_d   = op_i.key;
      end
    end else if (op_i.ext) begin
      // advance toward the head
      valid_d = right_i.valid;
      key_d   = right_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign link_o = '{valid: valid_q, ahead: ahead, key: key_q};

endmodule

/* sv/min_priority_queue_unit.sv */
// Channel   Role   Payload
// in_i      sink   cmd, key
// res_o     source extracted, status, count, current_min
//
// One item per cycle: every cell updates from its neighbors in the same cycle.
// A result appears in the cycle after its item is taken, held in an output register.
// Input stalls only while that register holds a result that is not taken.
// Reset empties the queue by clearing the cell valid bits; no sweep is needed.
module min_priority_queue_unit
  import mpq_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mpq_in_if.sink    in_i,
  mpq_out_if.source res_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  mpq_link_t link [CAPACITY];
  mpq_link_t head_link;
  mpq_link_t tail_link;
  mpq_op_t   op;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q;
  logic            accept, is_ins, full, empty;

  logic [KeyW-1:0]   extracted_q, extracted_d;
  mpq_status_e       status_q, status_d;
  logic [CntW-1:0]   res_cnt_q;
  logic [KeyW-1:0]   min_q, min_d;
  logic [CntW+CountW-1:0] cnt_wide;

  assign in_i.ready = !out_valid_q || res_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_ins     = (in_i.cmd == CMD_INSERT);
  assign full       = (cnt_q == CntW'(CAPACITY));
  assign empty      = (cnt_q == '0);

  assign op.ins = accept && is_ins && !full;
  assign op.ext = accept && !is_ins && !empty;
  assign op.key = in_i.key;

  assign head_link = '{valid: 1'b1, ahead: 1'b0, key: KeyAllOnes};
  assign tail_link = '{valid: 1'b0, ahead: 1'b1, key: KeyAllOnes};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mpq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .left_i  ((i == 0) ? head_link : link[(i == 0) ? 0 : i - 1]),
      .right_i ((i == CAPACITY - 1) ? tail_link
                                    : link[(i == CAPACITY - 1) ? i : i + 1]),
      .link_o  (link[i])
    );
  end

  always_comb begin
    cnt_d       = cnt_q;
    extracted_d = KeyAllOnes;
    status_d    = STATUS_OK;
    min_d       = link[0].valid ? link[0].key : KeyAllOnes;
    if (is_ins) begin
      if (full) begin
        status_d = STATUS_FULL;
      end else begin
        cnt_d = cnt_q + 1'b1;
        min_d = link[0].ahead ? in_i.key : link[0].key;
      end
    end else begin
      if (empty) begin
        status_d = STATUS_EMPTY;
      end else begin
        cnt_d       = cnt_q - 1'b1;
        extracted_d = link[0].key;
        min_d       = link[1].valid ? link[1].key : KeyAllOnes;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      extracted_q <= extracted_d;
      status_q    <= status_d;
      res_cnt_q   <= cnt_d;
      min_q       <= min_d;
    end
  end

  assign cnt_wide          = {{CountW{1'b0}}, res_cnt_q};
  assign res_o.valid       = out_valid_q;
  assign res_o.extracted   = extracted_q;
  assign res_o.status      = status_q;
  assign res_o.count       = cnt_wide[CountW-1:0];
  assign res_o.current_min = min_q;

`ifndef SYNTHESIS
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[0].valid == (cnt_q != '0))
    else $error("head cell valid disagrees with count");

  a_tail_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[CAPACITY-1].valid == full)
    else $error("tail cell valid disagrees with full");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("count beyond capacity");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[1].valid |-> (link[0].key <= link[1].key))
    else $error("head cell not the minimum");
`endif

endmodule
